>>> src/itom_pkg.sv
// Shared types and constants for the interval timer output model.
`default_nettype none

package itom_pkg;

    // Count field width and the wider addend that holds count + 1
    localparam int COUNT_W    = 17;
    localparam int ADD_W      = COUNT_W + 1;
    localparam int MODE_W     = 3;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = COUNT_W;

    // A written zero count stands for this value
    localparam logic [COUNT_W-1:0] COUNT_WRAP = 17'h10000;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_COUNTER_MODE  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_INITIAL_COUNT = 1'b1;

    // Counter modes; codes 6 and 7 fall back to terminal-count behavior
    typedef enum logic [MODE_W-1:0] {
        MODE_TERMINAL  = 3'd0,
        MODE_ONESHOT   = 3'd1,
        MODE_RATE      = 3'd2,
        MODE_SQUARE    = 3'd3,
        MODE_SW_STROBE = 3'd4,
        MODE_HW_STROBE = 3'd5
    } t_mode;

    // Divider state handed from one cell to the next
    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] rem;
    } t_div_state;

endpackage

`default_nettype wire

>>> src/itom_if.sv
// Valid/ready channel interfaces for the query and result beats.
`default_nettype none

interface itom_in_if #(
    parameter int TICK_WIDTH = 48
);
    logic                  valid;
    logic                  ready;
    logic [TICK_WIDTH-1:0] elapsed_ticks;

    modport source (output valid, output elapsed_ticks, input ready);
    modport sink   (input valid, input elapsed_ticks, output ready);
endinterface

interface itom_out_if #(
    parameter int TICK_WIDTH = 48
);
    logic                  valid;
    logic                  ready;
    logic                  out_level;
    logic                  has_transition;
    logic [TICK_WIDTH-1:0] next_change_tick;

    modport source (output valid, output out_level, output has_transition,
                    output next_change_tick, input ready);
    modport sink   (input valid, input out_level, input has_transition,
                    input next_change_tick, output ready);
endinterface

`default_nettype wire

>>> src/itom_cell.sv
// One restoring-division cell: folds one tick bit into the running remainder.
`default_nettype none

module itom_cell #(
    parameter int TICK_WIDTH = 48,
    parameter int BIT_IDX    = 47
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire  [itom_pkg::COUNT_W-1:0]        i_cnt,
    input  wire  itom_pkg::t_div_state          i_up,
    input  wire  [TICK_WIDTH-1:0]               i_ticks,
    output logic                                o_up_ready,
    input  wire                                 i_dn_ready,
    output itom_pkg::t_div_state                o_dn,
    output logic [TICK_WIDTH-1:0]               o_ticks
);

    logic                           r_valid;
    logic [itom_pkg::COUNT_W-1:0]   r_rem;
    logic [TICK_WIDTH-1:0]          r_ticks;

    logic [itom_pkg::COUNT_W:0]     w_trial;
    logic [itom_pkg::COUNT_W:0]     w_diff;
    logic [itom_pkg::COUNT_W-1:0]   n_rem;

    // Shift in the next tick bit and subtract the count if it fits
    always_comb begin
        w_trial = {i_up.rem, i_ticks[BIT_IDX]};
        w_diff  = w_trial - {1'b0, i_cnt};
        if (w_trial >= {1'b0, i_cnt}) begin
            n_rem = w_diff[itom_pkg::COUNT_W-1:0];
        end else begin
            n_rem = w_trial[itom_pkg::COUNT_W-1:0];
        end
    end

    // Take a beat when empty or when the next cell takes ours
    assign o_up_ready = !r_valid || i_dn_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_up_ready) begin
            r_valid <= i_up.valid;
        end
    end

    // Hold payload until a new beat arrives
    always_ff @(posedge i_clk) begin
        if (o_up_ready && i_up.valid) begin
            r_rem   <= n_rem;
            r_ticks <= i_ticks;
        end
    end

    assign o_dn.valid = r_valid;
    assign o_dn.rem   = r_rem;
    assign o_ticks    = r_ticks;

endmodule

`default_nettype wire

>>> src/itom_finish.sv
// Mode decode of level and next change, then saturating add into the result register.
`default_nettype none

module itom_finish #(
    parameter int TICK_WIDTH = 48
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire  [itom_pkg::MODE_W-1:0]         i_mode,
    input  wire  [itom_pkg::COUNT_W-1:0]        i_cnt,
    input  wire  itom_pkg::t_div_state          i_up,
    input  wire  [TICK_WIDTH-1:0]               i_ticks,
    output logic                                o_up_ready,
    itom_out_if.source                          o_out
);

    localparam int SUM_W = TICK_WIDTH + 1;

    // Decode stage registers
    logic                           r_a_valid;
    logic                           r_a_level;
    logic                           r_a_has;
    logic [TICK_WIDTH-1:0]          r_a_base;
    logic [itom_pkg::ADD_W-1:0]     r_a_add;

    // Result registers
    logic                           r_b_valid;
    logic                           r_b_level;
    logic                           r_b_has;
    logic [TICK_WIDTH-1:0]          r_b_next;

    logic                           w_b_ready;
    logic                           w_lt;
    logic                           w_eq;
    logic                           w_rem_zero;
    logic                           w_ticks_nz;
    logic                           w_rate_hit;
    logic                           w_sq_high;
    logic [itom_pkg::COUNT_W-1:0]   w_half;
    logic [itom_pkg::ADD_W-1:0]     w_cnt_x;
    logic [itom_pkg::ADD_W-1:0]     w_cnt_p1;
    logic [TICK_WIDTH-1:0]          w_period_base;
    logic                           n_level;
    logic                           n_has;
    logic [TICK_WIDTH-1:0]          n_base;
    logic [itom_pkg::ADD_W-1:0]     n_add;
    logic [SUM_W-1:0]               w_sum;
    logic [TICK_WIDTH-1:0]          n_next;

    assign w_b_ready  = !r_b_valid || o_out.ready;
    assign o_up_ready = !r_a_valid || w_b_ready;

    // Compare elapsed ticks with the count and locate the period start
    always_comb begin
        w_lt          = i_ticks < TICK_WIDTH'(i_cnt);
        w_eq          = i_ticks == TICK_WIDTH'(i_cnt);
        w_rem_zero    = i_up.rem == '0;
        w_ticks_nz    = i_ticks != '0;
        w_rate_hit    = w_rem_zero && w_ticks_nz;
        w_half        = itom_pkg::COUNT_W'((itom_pkg::ADD_W'(i_cnt) + 1'b1) >> 1);
        w_sq_high     = i_up.rem < w_half;
        w_cnt_x       = itom_pkg::ADD_W'(i_cnt);
        w_cnt_p1      = w_cnt_x + 1'b1;
        w_period_base = i_ticks - TICK_WIDTH'(i_up.rem);
    end

    // Pick level, presence of a change, and the base plus offset of it
    always_comb begin
        n_level = 1'b0;
        n_has   = 1'b1;
        n_base  = '0;
        n_add   = w_cnt_x;
        unique case (i_mode)
            itom_pkg::MODE_ONESHOT: begin
                n_level = w_lt;
                n_has   = w_lt;
            end
            itom_pkg::MODE_RATE: begin
                n_level = w_rate_hit;
                n_base  = w_period_base;
                n_add   = w_rate_hit ? w_cnt_x : w_cnt_p1;
            end
            itom_pkg::MODE_SQUARE: begin
                n_level = w_sq_high;
                n_base  = w_period_base;
                n_add   = w_sq_high ? itom_pkg::ADD_W'(w_half) : w_cnt_x;
            end
            itom_pkg::MODE_SW_STROBE, itom_pkg::MODE_HW_STROBE: begin
                n_level = w_eq;
                n_has   = w_lt || w_eq;
                n_add   = w_eq ? w_cnt_p1 : w_cnt_x;
            end
            default: begin
                n_level = !w_lt;
                n_has   = w_lt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_up_ready) begin
            r_a_valid <= i_up.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_up_ready && i_up.valid) begin
            r_a_level <= n_level;
            r_a_has   <= n_has;
            r_a_base  <= n_base;
            r_a_add   <= n_add;
        end
    end

    // Add the offset and saturate at all ones; zero when no change comes
    always_comb begin
        w_sum = {1'b0, r_a_base} + SUM_W'(r_a_add);
        if (!r_a_has) begin
            n_next = '0;
        end else if (w_sum[TICK_WIDTH]) begin
            n_next = '1;
        end else begin
            n_next = w_sum[TICK_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_b_ready) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_ready && r_a_valid) begin
            r_b_level <= r_a_level;
            r_b_has   <= r_a_has;
            r_b_next  <= n_next;
        end
    end

    assign o_out.valid            = r_b_valid;
    assign o_out.out_level        = r_b_level;
    assign o_out.has_transition   = r_b_has;
    assign o_out.next_change_tick = r_b_next;

endmodule

`default_nettype wire

>>> src/interval_timer_output_model.sv
// Interval timer output model: one timer channel's output level and next change tick.
//
// Usage: configure counter mode (index 0) and initial count (index 1) through the
// write port while no query is in flight. Each beat on i_in carries the ticks
// elapsed since the count was loaded; each beat on o_out returns the output level,
// whether a later change exists, and the tick of that change (saturating).
// The datapath is a row of TICK_WIDTH division cells, one per tick bit, each
// folding one bit into the remainder modulo the count, then a mode decode stage
// and the result register. One query enters per cycle and one result leaves per
// cycle while the receiver does not stall; the per-bit cell row sets that figure.
// Each cell and stage advances when its successor is empty or moving, so when
// the receiver stalls, beats pile up in the row and i_in.ready drops only once
// every stage holds a beat. Reset clears all valid flags, sets mode 3 and
// count 65536; no clearing pass is needed.
`default_nettype none

module interval_timer_output_model #(
    parameter int TICK_WIDTH = 48
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [itom_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  wire  [itom_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    itom_in_if.sink                             i_in,
    itom_out_if.source                          o_out
);

    logic [itom_pkg::MODE_W-1:0]    r_counter_mode;
    logic [itom_pkg::COUNT_W-1:0]   r_initial_count;
    logic [itom_pkg::COUNT_W-1:0]   w_cnt;

    itom_pkg::t_div_state           w_link  [0:TICK_WIDTH];
    logic [TICK_WIDTH-1:0]          w_ticks [0:TICK_WIDTH];
    logic                           w_rdy   [0:TICK_WIDTH];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter_mode  <= itom_pkg::MODE_SQUARE;
            r_initial_count <= itom_pkg::COUNT_WRAP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                itom_pkg::REG_COUNTER_MODE: begin
                    r_counter_mode <= i_cfg_wdata[itom_pkg::MODE_W-1:0];
                end
                itom_pkg::REG_INITIAL_COUNT: begin
                    r_initial_count <= i_cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    // A zero count stands for the wrap value
    assign w_cnt = (r_initial_count == '0) ? itom_pkg::COUNT_WRAP : r_initial_count;

    // Feed the head of the cell row
    assign w_link[0].valid = i_in.valid;
    assign w_link[0].rem   = '0;
    assign w_ticks[0]      = i_in.elapsed_ticks;
    assign i_in.ready      = w_rdy[0];

    // Division row, most significant tick bit first
    for (genvar g = 0; g < TICK_WIDTH; g++) begin : g_cell
        itom_cell #(
            .TICK_WIDTH (TICK_WIDTH),
            .BIT_IDX    (TICK_WIDTH - 1 - g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cnt      (w_cnt),
            .i_up       (w_link[g]),
            .i_ticks    (w_ticks[g]),
            .o_up_ready (w_rdy[g]),
            .i_dn_ready (w_rdy[g+1]),
            .o_dn       (w_link[g+1]),
            .o_ticks    (w_ticks[g+1])
        );
    end

    itom_finish #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_finish (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mode     (r_counter_mode),
        .i_cnt      (w_cnt),
        .i_up       (w_link[TICK_WIDTH]),
        .i_ticks    (w_ticks[TICK_WIDTH]),
        .o_up_ready (w_rdy[TICK_WIDTH]),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire

>>> test/interval_timer_output_model_tb.sv
// Self-checking testbench for the interval timer output model with random idling on both channels.
`timescale 1ns / 1ps

module interval_timer_output_model_tb;

    localparam int TICK_W          = 48;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 80;
    localparam int LONG_STALL      = 300;
    localparam int LATENCY         = TICK_W + 2;

    // Expected output of one query
    typedef struct packed {
        logic              level;
        logic              has_change;
        logic [TICK_W-1:0] change_tick;
    } t_outcome;

    logic                            i_clk;
    logic                            i_rst_n     = 1'b0;
    logic                            i_cfg_we    = 1'b0;
    logic [itom_pkg::CFG_ADDR_W-1:0] i_cfg_addr  = '0;
    logic [itom_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;

    itom_in_if  #(.TICK_WIDTH(TICK_W)) in_ch ();
    itom_out_if #(.TICK_WIDTH(TICK_W)) out_ch ();

    interval_timer_output_model #(
        .TICK_WIDTH (TICK_W)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // Channel settings as last written
    logic [itom_pkg::MODE_W-1:0]  mode_setting  = itom_pkg::MODE_SQUARE;
    logic [itom_pkg::COUNT_W-1:0] count_setting = itom_pkg::COUNT_WRAP;

    logic [TICK_W-1:0] ticks_to_send [$];
    t_outcome          pending_outcomes [$];
    t_outcome          want;

    int          err_count   = 0;
    int          cycle_count = 0;
    int          src_gap     = 0;
    int          sink_wait   = 0;
    int unsigned stall_req   = 0;
    int unsigned stall_ack   = 0;
    bit          no_idle     = 1'b0;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Saturating add of a count-sized step onto a tick value
    function automatic logic [TICK_W-1:0] tick_plus(input logic [TICK_W-1:0] base,
                                                    input logic [TICK_W-1:0] step);
        logic [TICK_W:0] total;
        total = {1'b0, base} + {1'b0, step};
        return total[TICK_W] ? '1 : total[TICK_W-1:0];
    endfunction

    // Output level and next change tick for one elapsed-tick query
    function automatic t_outcome timer_outcome(
        input logic [itom_pkg::MODE_W-1:0]  mode,
        input logic [itom_pkg::COUNT_W-1:0] count,
        input logic [TICK_W-1:0]            ticks
    );
        logic [TICK_W-1:0] period, phase, period_start, half;
        logic              hit;
        t_outcome          res;
        period       = (count == '0) ? TICK_W'(itom_pkg::COUNT_WRAP) : TICK_W'(count);
        phase        = ticks % period;
        period_start = ticks - phase;
        half         = (period + 1) >> 1;
        res          = '0;
        res.has_change = 1'b1;
        case (itom_pkg::t_mode'(mode))
            itom_pkg::MODE_ONESHOT: begin
                res.level       = ticks < period;
                res.has_change  = ticks < period;
                res.change_tick = tick_plus('0, period);
            end
            itom_pkg::MODE_RATE: begin
                hit             = (phase == '0) && (ticks != '0);
                res.level       = hit;
                res.change_tick = hit ? tick_plus(period_start, period)
                                      : tick_plus(period_start, period + 1);
            end
            itom_pkg::MODE_SQUARE: begin
                res.level       = phase < half;
                res.change_tick = res.level ? tick_plus(period_start, half)
                                            : tick_plus(period_start, period);
            end
            itom_pkg::MODE_SW_STROBE, itom_pkg::MODE_HW_STROBE: begin
                res.level = ticks == period;
                if (ticks < period)
                    res.change_tick = tick_plus('0, period);
                else if (ticks == period)
                    res.change_tick = tick_plus('0, period + 1);
                else
                    res.has_change = 1'b0;
            end
            // terminal count, and the two spare codes that fall back to it
            default: begin
                res.level       = ticks >= period;
                res.has_change  = ticks < period;
                res.change_tick = tick_plus('0, period);
            end
        endcase
        if (!res.has_change)
            res.change_tick = '0;
        return res;
    endfunction

    // Gap length: mostly none, sometimes short, rarely long
    function automatic int pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else if (roll < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Elapsed ticks: small values, period edges, half points, the saturation region or fully random
    function automatic logic [TICK_W-1:0] pick_ticks(input logic [TICK_W-1:0] period);
        logic [TICK_W-1:0] wide, anchor, half;
        int unsigned       roll;
        roll   = $urandom_range(0, 99);
        wide   = TICK_W'({$urandom(), $urandom()});
        anchor = wide - (wide % period);
        half   = (period + 1) >> 1;
        if (roll < 30)
            return TICK_W'($urandom_range(0, 32'(period) * 3 + 2));
        if (roll < 60) begin
            case ($urandom_range(0, 5))
                0:       return anchor;
                1:       return anchor + 1;
                2:       return anchor + period - 1;
                3:       return anchor + half;
                4:       return anchor + half - 1;
                default: return anchor + TICK_W'($urandom_range(0, 32'(period) - 1));
            endcase
        end
        if (roll < 75)
            return '1 - TICK_W'($urandom_range(0, 32'(period) * 2));
        return wide;
    endfunction

    // Write one register and update the predictor's copy
    task automatic cfg_write(input logic [itom_pkg::CFG_ADDR_W-1:0] index,
                             input logic [itom_pkg::CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= index;
        i_cfg_wdata <= value;
        if (index == itom_pkg::REG_COUNTER_MODE)
            mode_setting = value[itom_pkg::MODE_W-1:0];
        else
            count_setting = value[itom_pkg::COUNT_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Hold until every queued query is sent and every result is back
    task automatic wait_drained();
        while (ticks_to_send.size() != 0 || in_ch.valid || pending_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Driver: offer queued beats, record the expected result of each accepted one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid         <= 1'b0;
            in_ch.elapsed_ticks <= '0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                pending_outcomes.push_back(
                    timer_outcome(mode_setting, count_setting, in_ch.elapsed_ticks));
            if (!in_ch.valid || in_ch.ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    in_ch.valid <= 1'b0;
                end else if (ticks_to_send.size() != 0) begin
                    in_ch.valid         <= 1'b1;
                    in_ch.elapsed_ticks <= ticks_to_send.pop_front();
                    src_gap = pick_gap();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result beat against the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (pending_outcomes.size() == 0) begin
                    $error("result beat with no query pending");
                    err_count++;
                end else begin
                    want = pending_outcomes.pop_front();
                    if (out_ch.out_level !== want.level) begin
                        $error("out_level: expected %0d, got %0d",
                               want.level, out_ch.out_level);
                        err_count++;
                    end
                    if (out_ch.has_transition !== want.has_change) begin
                        $error("has_transition: expected %0d, got %0d",
                               want.has_change, out_ch.has_transition);
                        err_count++;
                    end
                    if (out_ch.next_change_tick !== want.change_tick) begin
                        $error("next_change_tick: expected %0h, got %0h",
                               want.change_tick, out_ch.next_change_tick);
                        err_count++;
                    end
                end
            end
            // start a long hold-off when one is requested
            if (stall_ack != stall_req) begin
                stall_ack = stall_req;
                sink_wait = LONG_STALL;
            end
            if (sink_wait > 0) begin
                sink_wait--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                sink_wait = pick_gap();
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        logic [itom_pkg::MODE_W-1:0]  mode_pick;
        logic [itom_pkg::COUNT_W-1:0] count_pick;
        logic [TICK_W-1:0]            period;

        in_ch.valid         = 1'b0;
        in_ch.elapsed_ticks = '0;
        out_ch.ready        = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: square wave at the wrapped count, including saturation
        ticks_to_send.push_back(TICK_W'(65535));
        ticks_to_send.push_back('1);

        // Each mode once, around the terminal count
        for (int m = 0; m < 8; m++) begin
            case (m)
                0:       count_pick = 17'd5;
                1:       count_pick = 17'd0;
                2:       count_pick = 17'd1;
                3:       count_pick = 17'd7;
                4:       count_pick = 17'd4;
                5:       count_pick = 17'd131071;
                6:       count_pick = 17'd65537;
                default: count_pick = 17'd2;
            endcase
            wait_drained();
            cfg_write(itom_pkg::REG_COUNTER_MODE, itom_pkg::CFG_DATA_W'(m));
            cfg_write(itom_pkg::REG_INITIAL_COUNT, count_pick);
            period = (count_pick == '0) ? TICK_W'(itom_pkg::COUNT_WRAP)
                                        : TICK_W'(count_pick);
            ticks_to_send.push_back(period - 1);
            ticks_to_send.push_back(period);
            ticks_to_send.push_back(m[0] ? '1 : period + 1);
        end

        // Random queries under a series of settings, extremes first
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            if (p < 8) begin
                mode_pick = itom_pkg::MODE_W'(p);
                case ((p * 5 + 3) % 8)
                    0:       count_pick = 17'd0;
                    1:       count_pick = 17'd1;
                    2:       count_pick = 17'd2;
                    3:       count_pick = 17'd3;
                    4:       count_pick = 17'd65535;
                    5:       count_pick = 17'd65536;
                    6:       count_pick = 17'd65537;
                    default: count_pick = 17'd131071;
                endcase
            end else begin
                mode_pick  = itom_pkg::MODE_W'($urandom_range(0, 7));
                count_pick = $urandom_range(0, 1)
                           ? itom_pkg::COUNT_W'($urandom_range(1, 24))
                           : itom_pkg::COUNT_W'($urandom_range(0, 131071));
            end
            cfg_write(itom_pkg::REG_COUNTER_MODE, itom_pkg::CFG_DATA_W'(mode_pick));
            cfg_write(itom_pkg::REG_INITIAL_COUNT, count_pick);
            no_idle = (p == 5);
            period  = (count_pick == '0) ? TICK_W'(itom_pkg::COUNT_WRAP)
                                         : TICK_W'(count_pick);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                ticks_to_send.push_back(pick_ticks(period));
            // back the pipe up against a stalled receiver
            if (p == 3 || p == 9)
                stall_req <= stall_req + 1;
        end

        wait_drained();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
